@@ rtl/core/sliding_window_median_assert.svh @@
// ---------------------------------------------------------------------------
// Sliding window median assertion macros
// Concurrent assertion shorthands used by the top-level filter file.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SWM_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SWM_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/swm_pkg.sv @@
// ---------------------------------------------------------------------------
// Sliding window median package
// Sizes, types, controller states and the command and status bundles.
// ---------------------------------------------------------------------------
package swm_pkg;

   localparam int WINDOW_MAX        = 64;
   localparam int SAMPLE_BITS       = 32;
   localparam int SAMPLE_FIELD_W    = 32;
   localparam int MEDIAN_FIELD_W    = 33;
   localparam int SIZE_W            = 7;
   localparam int COUNT_W           = $clog2(WINDOW_MAX + 1);
   localparam int SLOT_W            = $clog2(WINDOW_MAX);
   localparam int WINDOW_SIZE_RESET = 3;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SAMPLE_BITS:0]   median_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DELETE,
      ST_INSERT,
      ST_SELECT,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic delete_oldest;
      logic insert;
      logic select;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic replace;
      logic fills;
      logic full;
      logic within_size;
   } status_type;

endpackage

@@ rtl/core/swm_req_if.sv @@
// ---------------------------------------------------------------------------
// Sliding window median request channel
// Valid/ready channel carrying one sample word and its restart flag.
// ---------------------------------------------------------------------------
interface swm_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [swm_pkg::SAMPLE_FIELD_W-1:0] sample;
   logic                                     restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink   (input valid, input sample, input restart, output ready);
endinterface

@@ rtl/core/swm_rsp_if.sv @@
// ---------------------------------------------------------------------------
// Sliding window median response channel
// Valid/ready channel carrying one median word.
// ---------------------------------------------------------------------------
interface swm_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [swm_pkg::MEDIAN_FIELD_W-1:0] median_x2;

   modport source (output valid, output median_x2, input ready);
   modport sink   (input valid, input median_x2, output ready);
endinterface

@@ rtl/core/sliding_window_median.sv @@
// ---------------------------------------------------------------------------
// Sliding window median filter
// Running median over the most recent window_size signed samples.
// ---------------------------------------------------------------------------
// Usage: the request channel takes one word per sample (sample, restart). The
// response channel returns median_x2, twice the window median (for an even
// window the sum of the two middle samples). No response comes until the
// window holds window_size samples; after that every sample gives one word.
// restart empties the window before its sample enters it.
// Writing window_size through csr_we/csr_wdata empties the window; a size of
// zero acts as one and sizes above 64 act as 64. Write it only while idle.
// The controller handles one word at a time. A sample that does not fill the
// window goes through accept and insert, one that completes it also through
// select and output, and one that slides a full window also through delete.
// Accept reads the leaving sample from the ring RAM, delete shifts it out of
// the sorted cell row, insert shifts the new sample in, select picks the
// middle cells and output adds. The response is valid in the cycle after the
// add, in which the controller can already accept the next request. If the
// receiver stalls, the result sits in the output register during the next
// sample, which then waits at the add step until the output register drains.
// Reset returns window_size to 3 and empties the window; RAM and sorted cells
// are not cleared, since only entries holding live samples are ever read.
// ---------------------------------------------------------------------------
`include "sliding_window_median_assert.svh"

module sliding_window_median (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [swm_pkg::SIZE_W-1:0] csr_wdata,
   swm_req_if.sink                    req_bus,
   swm_rsp_if.source                  rsp_bus
);
   import swm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller only sequences; all window state lives in the datapath.
   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   swm_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_sample    (req_bus.sample),
      .req_restart   (req_bus.restart),
      .cmd           (cmd),
      .status        (status),
      .rsp_median_x2 (rsp_bus.median_x2)
   );

   // A result is only formed from a full window.
   `SWM_ASSERT_IMP(a_load_needs_full, clock, reset, cmd.load_out, status.full, "median loaded from a window that is not full")

   // A sample arriving at a full window must first remove the oldest one.
   `SWM_ASSERT_NXT(a_replace_deletes, clock, reset, cmd.accept && status.replace, cmd.delete_oldest, "full window not shifted before insert")

   // The fill count never runs past the window size.
   `SWM_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, status.within_size, "fill count exceeds window size")
endmodule

@@ rtl/core/swm_ram.sv @@
// ---------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/swm_ctrl.sv @@
// ---------------------------------------------------------------------------
// Sliding window median controller
// Sequences delete, insert, median select and output load for each word.
// ---------------------------------------------------------------------------
module swm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  swm_pkg::status_type status,
   output swm_pkg::cmd_type    cmd
);
   import swm_pkg::*;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.replace ? ST_DELETE : ST_INSERT;
            end
         end
         ST_DELETE: begin
            cmd.delete_oldest = 1'b1;
            state_in          = ST_INSERT;
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = status.fills ? ST_SELECT : ST_IDLE;
         end
         ST_SELECT: begin
            cmd.select = 1'b1;
            state_in   = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            // Wait here until the output register is free or being emptied.
            if (!out_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
endmodule

@@ rtl/core/swm_datapath.sv @@
// ---------------------------------------------------------------------------
// Sliding window median datapath
// Arrival-order ring in RAM, sorted row of compare cells, median adder.
// ---------------------------------------------------------------------------
module swm_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_we,
   input  logic [swm_pkg::SIZE_W-1:0]                csr_wdata,
   input  logic signed [swm_pkg::SAMPLE_FIELD_W-1:0] req_sample,
   input  logic                                      req_restart,
   input  swm_pkg::cmd_type                          cmd,
   output swm_pkg::status_type                       status,
   output logic signed [swm_pkg::MEDIAN_FIELD_W-1:0] rsp_median_x2
);
   import swm_pkg::*;

   localparam int SUM_W = COUNT_W + 1;

   logic [SIZE_W-1:0]  window_size_ff;
   logic [COUNT_W-1:0] fill_ff;
   logic [SLOT_W-1:0]  oldest_ff;
   logic               replace_ff;
   sample_type         sample_ff;
   sample_type         cells_ff [WINDOW_MAX];
   sample_type         cells_in [WINDOW_MAX];
   sample_type         lo_ff, hi_ff;
   median_type         median_ff;

   logic [COUNT_W-1:0]    size_eff;
   logic [COUNT_W-1:0]    insert_count;
   logic [SUM_W-1:0]      append_sum;
   logic [SUM_W-1:0]      oldest_next_sum;
   logic [SLOT_W-1:0]     write_slot;
   logic [SLOT_W-1:0]     oldest_next;
   logic [SLOT_W-1:0]     lo_idx, hi_idx;
   logic [SAMPLE_BITS-1:0] ram_rdata;
   sample_type            oldest_val;
   logic [WINDOW_MAX-1:0] above;

   // Size zero behaves as one, sizes past the cell row saturate.
   always_comb begin
      if (window_size_ff == '0) begin
         size_eff = COUNT_W'(1);
      end else if (int'(window_size_ff) > WINDOW_MAX) begin
         size_eff = COUNT_W'(WINDOW_MAX);
      end else begin
         size_eff = COUNT_W'(window_size_ff);
      end
   end

   assign insert_count    = replace_ff ? fill_ff - COUNT_W'(1) : fill_ff;
   assign append_sum      = SUM_W'(oldest_ff) + SUM_W'(fill_ff);
   assign oldest_next_sum = SUM_W'(oldest_ff) + SUM_W'(1);

   always_comb begin
      if (replace_ff) begin
         write_slot = oldest_ff;
      end else if (append_sum >= SUM_W'(size_eff)) begin
         write_slot = SLOT_W'(append_sum - SUM_W'(size_eff));
      end else begin
         write_slot = SLOT_W'(append_sum);
      end
      if (oldest_next_sum == SUM_W'(size_eff)) begin
         oldest_next = '0;
      end else begin
         oldest_next = SLOT_W'(oldest_next_sum);
      end
   end

   // For odd sizes both indexes land on the middle cell.
   assign lo_idx = SLOT_W'((size_eff - COUNT_W'(1)) >> 1);
   assign hi_idx = SLOT_W'(size_eff >> 1);

   assign status.replace     = !req_restart && (fill_ff == size_eff);
   assign status.fills       = (insert_count + COUNT_W'(1)) == size_eff;
   assign status.full        = (fill_ff == size_eff);
   assign status.within_size = (fill_ff <= size_eff);

   swm_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.insert),
      .wr_addr (write_slot),
      .wr_data (sample_ff),
      .rd_addr (oldest_ff),
      .rd_data (ram_rdata)
   );

   assign oldest_val = sample_type'(ram_rdata);

   // Each cell decides from itself and its neighbors. On delete every cell at
   // or above the leaving value takes its upper neighbor; on insert every cell
   // above the new value takes its lower neighbor or the new value itself.
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      sample_type del_val;
      sample_type ins_val;

      assign above[i] = (COUNT_W'(i) >= insert_count) || (cells_ff[i] > sample_ff);

      if (i == 0) begin : g_first
         assign ins_val = above[i] ? sample_ff : cells_ff[i];
      end else begin : g_rest
         assign ins_val = !above[i] ? cells_ff[i] :
                          (above[i-1] ? cells_ff[i-1] : sample_ff);
      end

      if (i < WINDOW_MAX - 1) begin : g_shift
         assign del_val = ((COUNT_W'(i + 1) < fill_ff) && (cells_ff[i] >= oldest_val)) ?
                          cells_ff[i+1] : cells_ff[i];
      end else begin : g_top
         assign del_val = cells_ff[i];
      end

      assign cells_in[i] = cmd.delete_oldest ? del_val : ins_val;
   end

   always_ff @(posedge clock) begin
      if (cmd.delete_oldest || cmd.insert) begin
         cells_ff <= cells_in;
      end
      if (cmd.accept) begin
         sample_ff  <= sample_type'(req_sample[SAMPLE_BITS-1:0]);
         replace_ff <= status.replace;
      end
      if (cmd.select) begin
         lo_ff <= cells_ff[lo_idx];
         hi_ff <= cells_ff[hi_idx];
      end
      if (cmd.load_out) begin
         median_ff <= median_type'(lo_ff) + median_type'(hi_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= SIZE_W'(WINDOW_SIZE_RESET);
         fill_ff        <= '0;
         oldest_ff      <= '0;
      end else if (csr_we) begin
         window_size_ff <= csr_wdata;
         fill_ff        <= '0;
         oldest_ff      <= '0;
      end else if (cmd.accept) begin
         if (req_restart || (fill_ff > size_eff)) begin
            fill_ff   <= '0;
            oldest_ff <= '0;
         end
      end else if (cmd.insert) begin
         fill_ff <= insert_count + COUNT_W'(1);
         if (replace_ff) begin
            oldest_ff <= oldest_next;
         end
      end
   end

   assign rsp_median_x2 = MEDIAN_FIELD_W'(median_ff);
endmodule

@@ sim/sliding_window_median_checker.sv @@
// ---------------------------------------------------------------------------
// Sliding window median checker
// Watches the sample, median and window size ports, keeps its own window of
// signed samples in arrival and sorted order, and compares every median word
// that the block returns with the oldest predicted one.
// ---------------------------------------------------------------------------
module sliding_window_median_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [swm_pkg::SIZE_W-1:0] csr_wdata,
   swm_req_if                         req_bus,
   swm_rsp_if                         rsp_bus,
   output int                         mismatch_count,
   output int                         pending_words
);
   timeunit 1ns;
   timeprecision 1ps;
   import swm_pkg::*;

   localparam int REPORT_LIMIT = 10;

   logic [SIZE_W-1:0] size_reg;
   sample_type        arrival_ring [WINDOW_MAX];
   sample_type        sorted_row   [WINDOW_MAX];
   int unsigned       held;
   int unsigned       head;
   median_type        median_backlog [$];

   function automatic int unsigned live_size();
      if (size_reg == '0) begin
         return 1;
      end
      if (size_reg > WINDOW_MAX) begin
         return WINDOW_MAX;
      end
      return int'(size_reg);
   endfunction

   // Moves one sample into the window and queues twice the median once the
   // window is full.
   task automatic slide_window(input sample_type s, input logic restart);
      int unsigned k;
      int unsigned slot;
      int unsigned pos;
      int unsigned i;
      sample_type  leaving;
      median_type  twice_median;
      k = live_size();
      if (restart || held > k) begin
         held = 0;
         head = 0;
      end
      if (held == k) begin
         slot    = head % k;
         leaving = arrival_ring[slot];
         pos     = held;
         for (i = 0; i < held; i++) begin
            if (sorted_row[i] == leaving) begin
               pos = i;
               break;
            end
         end
         if (pos < held) begin
            for (i = pos; i + 1 < held; i++) begin
               sorted_row[i] = sorted_row[i + 1];
            end
            held--;
         end
         head = (slot + 1) % k;
      end else begin
         slot = (head + held) % k;
      end
      arrival_ring[slot] = s;
      if (held < WINDOW_MAX) begin
         i = held;
         while (i > 0 && sorted_row[i - 1] > s) begin
            sorted_row[i] = sorted_row[i - 1];
            i--;
         end
         sorted_row[i] = s;
         held++;
      end
      if (held == k) begin
         if (k % 2 == 1) begin
            twice_median = {sorted_row[k / 2], 1'b0};
         end else begin
            twice_median = sorted_row[k / 2 - 1] + sorted_row[k / 2];
         end
         median_backlog.push_back(twice_median);
      end
   endtask

   always @(posedge clock) begin
      median_type wanted;
      if (reset) begin
         size_reg       = SIZE_W'(WINDOW_SIZE_RESET);
         held           = 0;
         head           = 0;
         mismatch_count = 0;
         median_backlog.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (median_backlog.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("checker: median word %0d with none predicted", rsp_bus.median_x2);
               end
               mismatch_count++;
            end else begin
               wanted = median_backlog.pop_front();
               if (rsp_bus.median_x2 !== wanted) begin
                  if (mismatch_count < REPORT_LIMIT) begin
                     $display("checker: median_x2 expected %0d, got %0d",
                              wanted, rsp_bus.median_x2);
                  end
                  mismatch_count++;
               end
            end
         end
         if (csr_we) begin
            size_reg = csr_wdata;
            held     = 0;
            head     = 0;
         end
         if (req_bus.valid && req_bus.ready) begin
            slide_window(req_bus.sample, req_bus.restart);
         end
      end
      pending_words <= median_backlog.size();
   end

endmodule

@@ sim/sliding_window_median_tb.sv @@
// ---------------------------------------------------------------------------
// Sliding window median testbench
// Drives sample words into the filter under random sender gaps and receiver
// stalls, runs a directed opening and then random phases over several window
// sizes (zero, one, the maximum and beyond it among them), and leaves all
// prediction and comparison to the checker that sits beside the block.
// ---------------------------------------------------------------------------
module sliding_window_median_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import swm_pkg::*;

   // Cycles to let pass once nothing is expected, so that a sample which
   // gives no median is surely finished before the window size changes.
   localparam int DRAIN_CYCLES = 16;
   localparam int ITEM_TARGET  = 600;
   localparam int TIMEOUT_NS   = 1_000_000;

   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [SIZE_W-1:0] csr_wdata;
   int                mismatch_count;
   int                pending_words;

   // While steady is set, neither side inserts gaps, so long stretches of
   // back-to-back traffic occur as well.
   bit                steady = 1'b0;

   swm_req_if req_bus ();
   swm_rsp_if rsp_bus ();

   sliding_window_median dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   sliding_window_median_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_words  (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs or never returns a predicted word.
   initial begin
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

   initial begin
      forever begin
         repeat ($urandom_range(100, 400)) @(posedge clock);
         steady = !steady;
      end
   end

   // Gap length for either side: mostly none, often a few cycles, and now
   // and then a long pause.
   function automatic int pick_gap();
      int r;
      if (steady) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(12, 40);
   endfunction

   // Sample values mix the extremes, a narrow band that makes duplicates in
   // the window likely, values next to the extremes and full random words.
   function automatic sample_type pick_sample();
      sample_type s;
      case ($urandom_range(0, 9))
         0: s = SAMPLE_MIN;
         1: s = SAMPLE_MAX;
         2, 3, 4: s = sample_type'($urandom_range(0, 8)) - sample_type'(4);
         5: s = SAMPLE_MIN + sample_type'($urandom_range(0, 3));
         6: s = SAMPLE_MAX - sample_type'($urandom_range(0, 3));
         default: s = sample_type'($urandom);
      endcase
      return s;
   endfunction

   function automatic int unsigned size_in_use(input logic [SIZE_W-1:0] size_value);
      if (size_value == '0) begin
         return 1;
      end
      if (size_value > WINDOW_MAX) begin
         return WINDOW_MAX;
      end
      return int'(size_value);
   endfunction

   // Offers one word after a random gap and returns at the edge where it is
   // taken. The payload is scrambled during the gap, since it is ignored
   // while valid is low.
   task automatic send_word(input sample_type s, input logic restart);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      repeat (gap) begin
         req_bus.valid   <= 1'b0;
         req_bus.sample  <= sample_type'($urandom);
         req_bus.restart <= 1'($urandom);
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.sample  <= s;
      req_bus.restart <= restart;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drops valid and waits until every predicted median has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
   endtask

   // The window size may only change while the block is idle, so the channel
   // is drained and the block given time to finish a sample without result.
   task automatic write_window_size(input logic [SIZE_W-1:0] size_value);
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= size_value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Receiver: ready runs of random length broken by random stalls.
   initial begin
      int run_len;
      int stall_len;
      rsp_bus.ready = 1'b0;
      forever begin
         run_len = $urandom_range(1, 24);
         repeat (run_len) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end
         stall_len = pick_gap();
         repeat (stall_len) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
      end
   end

   initial begin
      logic [SIZE_W-1:0] size_value;
      int unsigned       k;
      int                items;
      int                phase;
      int                phase_len;
      bit                paused_once;

      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.sample  = '0;
      req_bus.restart = 1'b0;
      items           = 0;
      paused_once     = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the size that reset leaves behind (three). The first
      // two words fill nothing; the third gives the first median.
      send_word(SAMPLE_MAX, 1'b0);
      send_word(SAMPLE_MIN, 1'b0);
      send_word(sample_type'(0), 1'b0);
      send_word(SAMPLE_MAX, 1'b0);
      send_word(SAMPLE_MAX, 1'b0);
      send_word(SAMPLE_MAX, 1'b0);
      send_word(SAMPLE_MIN, 1'b0);
      send_word(SAMPLE_MIN, 1'b0);
      send_word(SAMPLE_MIN, 1'b0);
      // A restart in a full window empties it before its own sample.
      send_word(sample_type'(-1), 1'b1);
      send_word(sample_type'(7), 1'b0);
      send_word(sample_type'(7), 1'b0);
      // Sliding out the -1 leaves three equal values in the window.
      send_word(sample_type'(7), 1'b0);
      // A restart on a full window, then one on a partial window, which throws it away.
      send_word(sample_type'(1), 1'b1);
      send_word(sample_type'(5), 1'b1);
      send_word(sample_type'(6), 1'b0);
      send_word(sample_type'(4), 1'b0);

      // An even window sums the two middle values, which reaches both ends of
      // the median range with the extreme samples.
      write_window_size(SIZE_W'(2));
      send_word(SAMPLE_MIN, 1'b0);
      send_word(SAMPLE_MIN, 1'b0);
      send_word(SAMPLE_MAX, 1'b0);
      send_word(SAMPLE_MAX, 1'b0);
      send_word(SAMPLE_MIN, 1'b0);
      send_word(sample_type'(-1), 1'b0);
      send_word(sample_type'(0), 1'b0);

      // Random phases. The first four hit the largest window, a window of one,
      // a size of zero and the largest register value; later ones are mostly
      // small windows so that medians come often.
      phase = 0;
      while (items < ITEM_TARGET) begin
         case (phase)
            0: size_value = SIZE_W'(WINDOW_MAX);
            1: size_value = SIZE_W'(1);
            2: size_value = '0;
            3: size_value = '1;
            default: begin
               if ($urandom_range(0, 5) == 0) begin
                  size_value = SIZE_W'($urandom_range(0, 127));
               end else begin
                  size_value = SIZE_W'($urandom_range(1, 9));
               end
            end
         endcase
         write_window_size(size_value);
         k         = size_in_use(size_value);
         phase_len = 2 * k + $urandom_range(16, 48);
         for (int n = 0; n < phase_len; n++) begin
            // Once, hold the sender back in the middle of a phase until every
            // median in flight has arrived.
            if (!paused_once && phase >= 4 && n == phase_len / 2) begin
               wait_for_drain();
               paused_once = 1'b1;
            end
            // Restarts are rare enough that most sequences fill and slide the
            // window, but they still break some of them.
            send_word(pick_sample(), $urandom_range(0, 4 * k + 8) == 0);
            items++;
         end
         phase++;
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_words == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
